@@ rtl/dteu_pkg.sv @@
package dteu_pkg;

	localparam int CODE_BITS = 31;
	localparam int PROD_W    = CODE_BITS + 4;
	localparam int ENC_BITS  = 31;
	localparam int ENC_MAX   = 6;
	localparam int MAX_BYTES = 7;
	localparam int CNT_W     = 3;

	typedef logic [7:0]           byte_t;
	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam byte_t CH_PCT   = 8'h25;
	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_ZERO  = 8'h30;
	localparam byte_t CH_NINE  = 8'h39;

	localparam code_t CODE_MAX = '1;

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'b001,
		MODE_PCT    = 3'b010,
		MODE_DIGITS = 3'b100
	} mode_t;

	typedef struct packed {
		cnt_t                    len;
		byte_t [MAX_BYTES-1:0]   bytes;
	} enc_t;

	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		cnt_t                  last_idx;
		logic                  marker;
		logic                  text_last;
	} burst_t;

	function automatic byte_t cont_byte(logic [5:0] bits);
		return {2'b10, bits};
	endfunction

	// legacy 1..6 byte UTF-8 form, lead byte first
	function automatic enc_t utf8_encode(logic [ENC_BITS-1:0] v);
		enc_t r;
		r.bytes = '0;
		if (v <= 31'h7F) begin
			r.len      = 3'd1;
			r.bytes[0] = v[7:0];
		end else if (v <= 31'h7FF) begin
			r.len      = 3'd2;
			r.bytes[0] = 8'd192 | {3'b000, v[10:6]};
			r.bytes[1] = cont_byte(v[5:0]);
		end else if (v <= 31'hFFFF) begin
			r.len      = 3'd3;
			r.bytes[0] = 8'd224 | {4'b0000, v[15:12]};
			r.bytes[1] = cont_byte(v[11:6]);
			r.bytes[2] = cont_byte(v[5:0]);
		end else if (v <= 31'h1FFFFF) begin
			r.len      = 3'd4;
			r.bytes[0] = 8'd240 | {5'b00000, v[20:18]};
			r.bytes[1] = cont_byte(v[17:12]);
			r.bytes[2] = cont_byte(v[11:6]);
			r.bytes[3] = cont_byte(v[5:0]);
		end else if (v <= 31'h3FFFFFF) begin
			r.len      = 3'd5;
			r.bytes[0] = 8'd248 | {6'b000000, v[25:24]};
			r.bytes[1] = cont_byte(v[23:18]);
			r.bytes[2] = cont_byte(v[17:12]);
			r.bytes[3] = cont_byte(v[11:6]);
			r.bytes[4] = cont_byte(v[5:0]);
		end else begin
			r.len      = 3'd6;
			r.bytes[0] = 8'd252 | {7'b0000000, v[30]};
			r.bytes[1] = cont_byte(v[29:24]);
			r.bytes[2] = cont_byte(v[23:18]);
			r.bytes[3] = cont_byte(v[17:12]);
			r.bytes[4] = cont_byte(v[11:6]);
			r.bytes[5] = cont_byte(v[5:0]);
		end
		return r;
	endfunction

endpackage

@@ rtl/dteu_if.sv @@
interface dteu_in_if import dteu_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  text_last;

	modport source(output valid, in_byte, text_last, input ready);
	modport sink(input valid, in_byte, text_last, output ready);
endinterface

interface dteu_out_if import dteu_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  byte_valid;
	logic  run_last;
	logic  text_end;

	modport source(output valid, out_byte, byte_valid, run_last, text_end, input ready);
	modport sink(input valid, out_byte, byte_valid, run_last, text_end, output ready);
endinterface

@@ rtl/dteu_scan.sv @@
module dteu_scan import dteu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  byte_t  in_byte,
	input  logic   text_last,
	output burst_t burst,
	output logic   burst_load
);

	mode_t mode_q, mode_mid;
	code_t code_q, val_mid, enc_val, sat_val;
	logic  is_dig, is_pct, is_quo;
	logic  seg0_pct, seg0_enc, plain_act, plain_emit, seg2_pct, seg2_enc;
	byte_t dig;
	logic [PROD_W-1:0] prod;
	enc_t  enc;
	cnt_t  seg0_len, seg2_len, off2, total;
	byte_t [MAX_BYTES-1:0] seg0, seg2, list;

	assign is_dig = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_pct = in_byte == CH_PCT;
	assign is_quo = in_byte == CH_QUOTE;
	assign dig    = in_byte - CH_ZERO;

	assign prod = (PROD_W'(code_q) << 3) + (PROD_W'(code_q) << 1) + PROD_W'(dig[3:0]);
	assign sat_val = (prod > PROD_W'(CODE_MAX)) ? CODE_MAX : prod[CODE_BITS-1:0];

	always_comb begin
		seg0_pct  = 1'b0;
		seg0_enc  = 1'b0;
		plain_act = 1'b0;
		mode_mid  = mode_q;
		val_mid   = code_q;
		case (mode_q)
			MODE_PCT: begin
				if (is_dig) begin
					mode_mid = MODE_DIGITS;
					val_mid  = CODE_BITS'(dig[3:0]);
				end else if (is_pct) begin
					seg0_pct = 1'b1;
					mode_mid = MODE_PLAIN;
				end else begin
					seg0_pct  = 1'b1;
					plain_act = 1'b1;
				end
			end
			MODE_DIGITS: begin
				if (is_dig) begin
					val_mid = sat_val;
				end else begin
					seg0_enc  = 1'b1;
					val_mid   = '0;
					plain_act = 1'b1;
				end
			end
			default: begin
				plain_act = 1'b1;
			end
		endcase
		if (plain_act) begin
			mode_mid = is_pct ? MODE_PCT : MODE_PLAIN;
		end
	end

	assign plain_emit = plain_act & ~is_pct & ~is_quo;
	assign seg2_pct   = text_last & (mode_mid == MODE_PCT);
	assign seg2_enc   = text_last & (mode_mid == MODE_DIGITS);

	// at most one of the two segments ever needs the encoder
	assign enc_val = seg0_enc ? code_q : val_mid;
	assign enc     = utf8_encode(ENC_BITS'(enc_val));

	always_comb begin
		seg0 = '0;
		seg2 = '0;
		if (seg0_pct) begin
			seg0[0] = CH_PCT;
		end else begin
			seg0 = enc.bytes;
		end
		if (seg2_pct) begin
			seg2[0] = CH_PCT;
		end else begin
			seg2 = enc.bytes;
		end
	end

	assign seg0_len = seg0_pct ? 3'd1 : (seg0_enc ? enc.len : 3'd0);
	assign seg2_len = seg2_pct ? 3'd1 : (seg2_enc ? enc.len : 3'd0);
	assign off2     = seg0_len + cnt_t'(plain_emit);
	assign total    = off2 + seg2_len;

	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			list[i] = '0;
			if (i < int'(seg0_len)) begin
				list[i] = seg0[i];
			end else if (plain_emit && (i == int'(seg0_len))) begin
				list[i] = in_byte;
			end else if (i < int'(total)) begin
				list[i] = seg2[cnt_t'(i - int'(off2))];
			end
		end
	end

	assign burst.bytes     = list;
	assign burst.marker    = total == '0;
	assign burst.last_idx  = (total == '0) ? '0 : total - 3'd1;
	assign burst.text_last = text_last;
	assign burst_load      = accept & ((total != '0) | text_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			code_q <= '0;
		end else if (accept) begin
			mode_q <= text_last ? MODE_PLAIN : mode_mid;
			code_q <= text_last ? '0 : val_mid;
		end
	end

	a_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_DIGITS) |-> (code_q == '0))
		else $error("digit value held outside a digit run");

	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text_last) |=> (mode_q == MODE_PLAIN))
		else $error("scan mode not cleared at end of text");

	a_end_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && text_last) |-> burst_load)
		else $error("end of text produced no result");

endmodule

@@ rtl/dteu_burst.sv @@
module dteu_burst import dteu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  burst_t       burst,
	output logic         load_ok,
	dteu_out_if.source   dst
);

	burst_t buf_q;
	cnt_t   idx_q;
	logic   full_q;
	logic   at_end, xfer;

	assign at_end  = idx_q == buf_q.last_idx;
	assign xfer    = full_q & dst.ready;
	assign load_ok = ~full_q | (dst.ready & at_end);

	assign dst.valid      = full_q;
	assign dst.out_byte   = buf_q.bytes[idx_q];
	assign dst.byte_valid = ~buf_q.marker;
	assign dst.run_last   = at_end;
	assign dst.text_end   = at_end & buf_q.text_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			if (at_end) begin
				full_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= burst;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (idx_q <= buf_q.last_idx))
		else $error("burst index past last byte");

	a_marker_single: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && buf_q.marker) |-> (buf_q.last_idx == '0))
		else $error("end marker with more than one transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !(dst.ready && at_end)) |-> !load)
		else $error("burst reloaded before drained");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && at_end && !load) |=> !full_q)
		else $error("burst still held after final transfer");

endmodule

@@ rtl/decimal_escape_to_utf8.sv @@
// Escaped text to UTF-8 converter. Takes one text byte per transfer; "%" plus decimal digits
// becomes the legacy 1..6 byte UTF-8 form of the value (saturating at 2^31-1), "%%" gives "%",
// a double quote is dropped, and a pending escape is flushed on the byte marked text_last.
// Each input byte yields 0..7 output transfers; run_last marks the final one of a byte and
// text_end the final one of the text (a lone end marker with byte_valid low if nothing else
// came out). Results appear in the cycle after the input transfer. Input rate is one byte per
// cycle while the output is ready and each byte yields at most one output byte; a byte yielding
// n bytes holds the single 7-entry output burst register, which drains one byte per cycle while
// the output is ready, and the next input byte is taken in the cycle its last byte leaves.
module decimal_escape_to_utf8 import dteu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dteu_in_if.sink    text_in,
	dteu_out_if.source utf8_out
);

	burst_t burst;
	logic   burst_load;
	logic   load_ok;
	logic   accept;

	assign text_in.ready = load_ok;
	assign accept        = text_in.valid & load_ok;

	dteu_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (text_in.in_byte),
		.text_last  (text_in.text_last),
		.burst      (burst),
		.burst_load (burst_load)
	);

	dteu_burst u_burst (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (burst_load),
		.burst   (burst),
		.load_ok (load_ok),
		.dst     (utf8_out)
	);

endmodule
